FILE: rtl/ahcfl_pkg.sv
package ahcfl_pkg;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic [5:0] buf_index;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic [2:0] link_status;
    } res_t;

    typedef enum logic [2:0] {
        MODE_HUNT = 3'd0,
        MODE_BODY = 3'd1,
        MODE_HIGH = 3'd2,
        MODE_LOW  = 3'd3,
        MODE_GOOD = 3'd4,
        MODE_TX   = 3'd5
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RX_W2,
        ST_TX_RD,
        ST_HOST_RD,
        ST_SUM,
        ST_APP_LO,
        ST_APP_END,
        ST_RESP
    } ctrl_state_t;

    localparam logic [2:0] CMD_RX       = 3'd0;
    localparam logic [2:0] CMD_TX_READY = 3'd1;
    localparam logic [2:0] CMD_HOST_WR  = 3'd2;
    localparam logic [2:0] CMD_HOST_RD  = 3'd3;
    localparam logic [2:0] CMD_START    = 3'd4;
    localparam logic [2:0] CMD_REARM    = 3'd5;

    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_ENQ   = 8'h05;
    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // ASCII hex digit to value; letters map through '7' so 'A' gives 10
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c <= CH_NINE)
            return c - CH_ZERO;
        return c - CH_SEVEN;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return {4'b0, n} + CH_ZERO;
        return {4'b0, n} + CH_SEVEN;
    endfunction

endpackage

FILE: rtl/ascii_hex_checksum_frame_link.sv
// Framed byte link with ASCII hex checksum over one shared frame buffer of
// BUF_DEPTH bytes, held in a single-port-write, single-port-read memory with
// a registered read. Requests are taken one at a time: a request is accepted
// only when the sequencer is idle, and every request returns exactly one
// result through an output register. A receive byte that restarts a frame
// or carries the final digit makes a second buffer write, and a tx-ready or
// host read waits for the memory read, before the result is registered.
// Start tx walks the buffer through the memory read port at one byte per
// cycle. A stalled result holds the sequencer.
module ascii_hex_checksum_frame_link #(
    parameter int BUF_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ahcfl_pkg::item_t item,
    output logic             result_valid,
    input  logic             result_stall,
    output ahcfl_pkg::res_t  result
);

    import ahcfl_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    ahcfl_mem #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ahcfl_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    // a byte is only handed out while transmitting
    a_tx_in_tx_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.tx_valid) |-> (result.link_status == MODE_TX))
        else $error("tx byte outside transmit mode");

    a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.tx_valid) |-> (result.tx_byte == 8'h00))
        else $error("tx byte set without tx valid");

    a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.tx_valid) |-> (result.read_data == 8'h00))
        else $error("read data and tx byte in one result");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("read and write to the same buffer entry");

    // a new request is only taken once the previous result left the sequencer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("request accepted while busy");

endmodule

FILE: rtl/ahcfl_mem.sv
module ahcfl_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] store [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ahcfl_ctrl.sv
module ahcfl_ctrl #(
    parameter int BUF_DEPTH = 64,
    parameter int AW        = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ahcfl_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output ahcfl_pkg::res_t     result,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [7:0]          mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  logic [7:0]          mem_rdata
);

    import ahcfl_pkg::*;

    localparam logic [AW-1:0] POS_LIM  = AW'(BUF_DEPTH - 2);
    localparam logic [AW-1:0] SCAN_LIM = AW'(BUF_DEPTH - 3);
    localparam logic [AW-1:0] LAST     = AW'(BUF_DEPTH - 1);

    ctrl_state_t   state_reg, state_next;
    mode_t         mode_reg, mode_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg, out_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic [AW-1:0] w2_addr_reg, w2_addr_next;
    logic [7:0]    w2_data_reg, w2_data_next;
    logic          res_tx_valid_reg, res_tx_valid_next;
    logic [7:0]    res_tx_byte_reg, res_tx_byte_next;
    logic [7:0]    res_read_reg, res_read_next;

    logic [AW-1:0] pos_adv;
    logic          starter;
    logic          term;
    logic          idx_ok;
    logic [AW-1:0] idx_addr;

    assign pos_adv  = (pos_reg < POS_LIM) ? pos_reg + 1'b1 : pos_reg;
    assign starter  = (item.data_byte == CH_ACK) || (item.data_byte == CH_ENQ);
    assign term     = (item.data_byte == CH_ETX) || (item.data_byte == CH_EOT);
    assign idx_ok   = 32'(item.buf_index) < BUF_DEPTH;
    assign idx_addr = AW'(item.buf_index);

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        pos_next          = pos_reg;
        sum_next          = sum_reg;
        out_valid_next    = out_valid_reg;
        out_next          = out_reg;
        scan_next         = scan_reg;
        w2_addr_next      = w2_addr_reg;
        w2_data_next      = w2_data_reg;
        res_tx_valid_next = res_tx_valid_reg;
        res_tx_byte_next  = res_tx_byte_reg;
        res_read_next     = res_read_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = '0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    res_tx_valid_next = 1'b0;
                    res_tx_byte_next  = '0;
                    res_read_next     = '0;
                    state_next        = ST_RESP;
                    case (item.cmd)
                        CMD_RX:
                        begin
                            if (mode_reg != MODE_TX && mode_reg != MODE_GOOD)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_adv;
                                mem_wdata = item.data_byte;
                                pos_next  = pos_adv;
                                if (starter)
                                begin
                                    // restart: byte lands at the advanced slot and at slot 0
                                    mode_next    = MODE_BODY;
                                    pos_next     = '0;
                                    sum_next     = item.data_byte;
                                    w2_addr_next = '0;
                                    w2_data_next = item.data_byte;
                                    state_next   = ST_RX_W2;
                                end
                                else
                                begin
                                    case (mode_reg)
                                        MODE_HUNT:
                                        begin
                                        end
                                        MODE_BODY:
                                        begin
                                            sum_next = sum_reg + item.data_byte;
                                            if (term)
                                            begin
                                                mem_wdata = '0;
                                                mode_next = MODE_HIGH;
                                            end
                                        end
                                        MODE_HIGH:
                                        begin
                                            mem_wdata = '0;
                                            mode_next = (digit_value(item.data_byte) ==
                                                         {4'b0, sum_reg[7:4]}) ?
                                                        MODE_LOW : MODE_HUNT;
                                        end
                                        MODE_LOW:
                                        begin
                                            mem_wdata    = '0;
                                            mode_next    = (digit_value(item.data_byte) ==
                                                            {4'b0, sum_reg[3:0]}) ?
                                                           MODE_GOOD : MODE_HUNT;
                                            w2_addr_next = LAST;
                                            w2_data_next = '0;
                                            state_next   = ST_RX_W2;
                                        end
                                        default:
                                        begin
                                            mode_next = MODE_HUNT;
                                            pos_next  = '0;
                                        end
                                    endcase
                                end
                            end
                        end
                        CMD_TX_READY:
                        begin
                            if (mode_reg == MODE_TX)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_reg;
                                state_next = ST_TX_RD;
                            end
                        end
                        CMD_HOST_WR:
                        begin
                            mem_we    = idx_ok;
                            mem_waddr = idx_addr;
                            mem_wdata = item.data_byte;
                        end
                        CMD_HOST_RD:
                        begin
                            if (idx_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_addr;
                                state_next = ST_HOST_RD;
                            end
                        end
                        CMD_START:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            scan_next  = '0;
                            sum_next   = '0;
                            state_next = ST_SUM;
                        end
                        CMD_REARM:
                        begin
                            mode_next = MODE_HUNT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RX_W2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = w2_addr_reg;
                mem_wdata  = w2_data_reg;
                state_next = ST_RESP;
            end
            ST_TX_RD:
            begin
                state_next = ST_RESP;
                if (mem_rdata == '0)
                begin
                    mode_next = MODE_HUNT;
                end
                else
                begin
                    res_tx_valid_next = 1'b1;
                    res_tx_byte_next  = mem_rdata;
                    if (pos_reg == LAST)
                    begin
                        // ran off the end: clear slot 0 so the next ready ends the send
                        pos_next  = '0;
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_HOST_RD:
            begin
                res_read_next = mem_rdata;
                state_next    = ST_RESP;
            end
            ST_SUM:
            begin
                // mem_rdata holds the entry at scan_reg
                if (scan_reg < SCAN_LIM && mem_rdata != '0)
                begin
                    sum_next  = sum_reg + mem_rdata;
                    scan_next = scan_reg + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = scan_reg + 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = scan_reg;
                    mem_wdata  = hex_char(sum_reg[7:4]);
                    state_next = ST_APP_LO;
                end
            end
            ST_APP_LO:
            begin
                mem_we     = 1'b1;
                mem_waddr  = scan_reg + AW'(1);
                mem_wdata  = hex_char(sum_reg[3:0]);
                state_next = ST_APP_END;
            end
            ST_APP_END:
            begin
                mem_we     = 1'b1;
                mem_waddr  = scan_reg + AW'(2);
                mem_wdata  = '0;
                mem_re     = 1'b1;
                mem_raddr  = '0;
                mode_next  = MODE_TX;
                pos_next   = '0;
                state_next = ST_TX_RD;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.tx_valid    = res_tx_valid_reg;
                    out_next.tx_byte     = res_tx_byte_reg;
                    out_next.read_data   = res_read_reg;
                    out_next.link_status = mode_reg;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_GOOD;
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg          <= out_next;
        scan_reg         <= scan_next;
        w2_addr_reg      <= w2_addr_next;
        w2_data_reg      <= w2_data_next;
        res_tx_valid_reg <= res_tx_valid_next;
        res_tx_byte_reg  <= res_tx_byte_next;
        res_read_reg     <= res_read_next;
    end

endmodule
